[rtl/prc_pkg.sv]
`default_nettype none

package prc_pkg;

    // Q16.16 data path
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned LIMIT_W = 31;

    // error sum and difference keep one extra bit
    localparam int unsigned PAIR_W = DATA_W + 1;
    // product of a pair magnitude and a 32-bit gain
    localparam int unsigned PROD_W = PAIR_W + DATA_W;
    // rounded magnitude after the 2^-16 scale, and its signed form
    localparam int unsigned QMAG_W = PROD_W - FRAC_W;
    localparam int unsigned TERM_W = QMAG_W + 1;
    // integral accumulate and final three-term sum
    localparam int unsigned IACC_W = TERM_W + 1;
    localparam int unsigned SUM_W  = TERM_W + 2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TERM_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_CLAMP  = 3'd4;

    // reset values
    localparam logic [DATA_W-1:0]  PROP_GAIN_RST   = 32'd98304;
    localparam logic [DATA_W-1:0]  INTEG_GAIN_RST  = 32'd131;
    localparam logic [DATA_W-1:0]  DERIV_GAIN_RST  = 32'd8192000;
    localparam logic [LIMIT_W-1:0] TERM_LIMIT_RST  = 31'd26214400;
    localparam logic               DERIV_CLAMP_RST = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0]  prop_gain;
        logic [DATA_W-1:0]  integ_gain_dt;
        logic [DATA_W-1:0]  deriv_gain_over_dt;
        logic [LIMIT_W-1:0] term_limit;
        logic               deriv_clamp_enable;
    } prc_cfg_t;

    // one classified request handed from front to back
    typedef struct packed {
        logic signed [DATA_W-1:0] err;
        logic signed [PAIR_W-1:0] err_sum;
        logic signed [PAIR_W-1:0] err_diff;
    } prc_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } prc_q_status_t;

endpackage

`default_nettype wire

[rtl/prc_queue.sv]
`default_nettype none

module prc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire prc_pkg::prc_job_t push_job,
    input  wire logic              pop,
    output prc_pkg::prc_job_t      head_job,
    output prc_pkg::prc_q_status_t status
);
    import prc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    prc_job_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_job     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

[rtl/prc_front.sv]
`default_nettype none

module prc_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [prc_pkg::DATA_W-1:0] in_error,
    input  wire prc_pkg::prc_q_status_t         q_status,
    output logic                                push,
    output prc_pkg::prc_job_t                   push_job
);
    import prc_pkg::*;

    logic signed [DATA_W-1:0] prev_error_reg;

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    // form sum and difference against the previous error at full width
    assign push_job.err      = in_error;
    assign push_job.err_sum  = PAIR_W'(in_error) + PAIR_W'(prev_error_reg);
    assign push_job.err_diff = PAIR_W'(in_error) - PAIR_W'(prev_error_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_error_reg <= '0;
        else if (push)
            prev_error_reg <= in_error;
    end

endmodule

`default_nettype wire

[rtl/prc_back.sv]
`default_nettype none

module prc_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire prc_pkg::prc_cfg_t           cfg,
    input  wire prc_pkg::prc_q_status_t      q_status,
    input  wire prc_pkg::prc_job_t           head_job,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [prc_pkg::DATA_W-1:0]       out_drive
);
    import prc_pkg::*;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);
    localparam logic signed [DATA_W-1:0] DRIVE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DRIVE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    function automatic logic [PAIR_W-1:0] mag_of(input logic signed [PAIR_W-1:0] v);
        mag_of = v[PAIR_W-1] ? PAIR_W'(-v) : PAIR_W'(v);
    endfunction

    // round half away from zero after the 2^-16 scale, then restore sign
    function automatic logic signed [TERM_W-1:0] scale_term(input logic [PROD_W-1:0] mag,
                                                           input logic neg);
        logic [PROD_W-1:0] rounded;
        logic signed [TERM_W-1:0] pos;
        rounded = mag + ROUND_HALF;
        pos = signed'({1'b0, rounded[PROD_W-1:FRAC_W]});
        scale_term = neg ? -pos : pos;
    endfunction

    logic adv;

    // stage 1: products of magnitudes
    logic              s1_valid_reg;
    logic [PROD_W-1:0] s1_p_mag_reg, s1_i_mag_reg, s1_d_mag_reg;
    logic              s1_p_neg_reg, s1_i_neg_reg, s1_d_neg_reg;
    // stage 2: signed scaled terms
    logic                     s2_valid_reg;
    logic signed [TERM_W-1:0] s2_p_reg, s2_i_reg, s2_d_reg;
    // stage 3: clamped terms, integral state
    logic                     s3_valid_reg;
    logic signed [TERM_W-1:0] s3_p_reg, s3_d_reg;
    logic signed [DATA_W-1:0] s3_i_reg;
    logic signed [DATA_W-1:0] integral_reg;
    // stage 4: output register
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        out_drive_reg;

    logic signed [PAIR_W-1:0] err_wide;
    logic [PAIR_W-1:0]        p_mag, i_mag, d_mag;
    logic signed [IACC_W-1:0] i_acc, i_lim;
    logic signed [DATA_W-1:0] i_next;
    logic signed [TERM_W-1:0] d_lim, d_next;
    logic signed [SUM_W-1:0]  total;
    logic [DATA_W-1:0]        drive_next;

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !q_status.empty;

    assign err_wide = PAIR_W'(head_job.err);
    assign p_mag    = mag_of(err_wide);
    assign i_mag    = mag_of(head_job.err_sum);
    assign d_mag    = mag_of(head_job.err_diff);

    always_comb
    begin
        i_acc = IACC_W'(integral_reg) + IACC_W'(s2_i_reg);
        i_lim = signed'(IACC_W'(cfg.term_limit));
        if (i_acc > i_lim)
            i_next = DATA_W'(i_lim);
        else if (i_acc < -i_lim)
            i_next = DATA_W'(-i_lim);
        else
            i_next = DATA_W'(i_acc);

        d_lim  = signed'(TERM_W'(cfg.term_limit));
        d_next = s2_d_reg;
        if (cfg.deriv_clamp_enable)
        begin
            if (s2_d_reg > d_lim)
                d_next = d_lim;
            else if (s2_d_reg < -d_lim)
                d_next = -d_lim;
        end
    end

    always_comb
    begin
        total = SUM_W'(s3_p_reg) + SUM_W'(s3_i_reg) + SUM_W'(s3_d_reg);
        if (total > SUM_W'(DRIVE_MAX))
            drive_next = DRIVE_MAX;
        else if (total < SUM_W'(DRIVE_MIN))
            drive_next = DRIVE_MIN;
        else
            drive_next = DATA_W'(total);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= !q_status.empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            if (s2_valid_reg)
                integral_reg <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_p_mag_reg <= PROD_W'(p_mag) * PROD_W'(cfg.prop_gain);
            s1_i_mag_reg <= PROD_W'(i_mag) * PROD_W'(cfg.integ_gain_dt);
            s1_d_mag_reg <= PROD_W'(d_mag) * PROD_W'(cfg.deriv_gain_over_dt);
            s1_p_neg_reg <= head_job.err[DATA_W-1];
            s1_i_neg_reg <= head_job.err_sum[PAIR_W-1];
            s1_d_neg_reg <= head_job.err_diff[PAIR_W-1];

            s2_p_reg <= scale_term(s1_p_mag_reg, s1_p_neg_reg);
            s2_i_reg <= scale_term(s1_i_mag_reg, s1_i_neg_reg);
            s2_d_reg <= scale_term(s1_d_mag_reg, s1_d_neg_reg);

            s3_p_reg <= s2_p_reg;
            s3_i_reg <= i_next;
            s3_d_reg <= d_next;

            out_drive_reg <= drive_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_drive = out_drive_reg;

endmodule

`default_nettype wire

[rtl/pid_rate_controller_unit.sv]
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[31:0] rate_error (signed Q16.16)
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[31:0] drive (signed Q16.16)
// cfg       in   cfg_we (no ready)            cfg_index, cfg_data[31:0]
//
// One request per cycle sustained while m_axis_tready holds; drive is registered
// through the queue write at accept, then the product, round, clamp/integrate and
// sum/saturate stages.
// The integral feedback closes inside the clamp stage, one update per request.
// Reset clears previous error, integral term, queue and stage valid bits and
// loads the register defaults. The back pipeline holds while m_axis stalls;
// the input keeps taking requests until the QUEUE_DEPTH-entry queue fills.

module pid_rate_controller_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [prc_pkg::DATA_W-1:0]        s_axis_tdata,  // [31:0] rate_error
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [prc_pkg::DATA_W-1:0]             m_axis_tdata,  // [31:0] drive
    input  wire logic                              cfg_we,
    input  wire logic [prc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [prc_pkg::DATA_W-1:0]        cfg_data
);
    import prc_pkg::*;

    prc_cfg_t      cfg_reg;
    prc_q_status_t q_status;
    prc_job_t      push_job, head_job;
    logic          push, pop;

    // register file; unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain          <= PROP_GAIN_RST;
            cfg_reg.integ_gain_dt      <= INTEG_GAIN_RST;
            cfg_reg.deriv_gain_over_dt <= DERIV_GAIN_RST;
            cfg_reg.term_limit         <= TERM_LIMIT_RST;
            cfg_reg.deriv_clamp_enable <= DERIV_CLAMP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:   cfg_reg.prop_gain          <= cfg_data;
                REG_INTEG_GAIN:  cfg_reg.integ_gain_dt      <= cfg_data;
                REG_DERIV_GAIN:  cfg_reg.deriv_gain_over_dt <= cfg_data;
                REG_TERM_LIMIT:  cfg_reg.term_limit         <= cfg_data[LIMIT_W-1:0];
                REG_DERIV_CLAMP: cfg_reg.deriv_clamp_enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // front: take the error, pair it with the previous one
    prc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_error (signed'(s_axis_tdata)),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    // decouple front and back
    prc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // back: gains, integrate, clamp, sum, saturate
    prc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .head_job  (head_job),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_drive (m_axis_tdata)
    );

endmodule

`default_nettype wire

[rtl/prc_checker.sv]
`default_nettype none

module prc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("drive request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("drive changed while stalled");

    // input only backs up when the output side stalled the cycle before
    a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output stall");

    // the pipeline starts empty; nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("drive valid right after reset");

endmodule

bind pid_rate_controller_unit prc_checker u_prc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
